>>> src/osao_pkg.sv
// osao_pkg: shared types and codes for the subset angle ordering block.
// Beat structs for both channels, status and operation codes, register indexes.
// No dependencies.
package osao_pkg;

    localparam int SUBSET_W = 6;
    localparam int SLOT_W   = 8;
    localparam int ANGLE_W  = 14;
    localparam int STATUS_W = 2;
    localparam int NSUB_W   = 7;
    localparam int NANG_W   = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic OP_BUILD  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOBUILD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_SUBSETS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLES      = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [SUBSET_W-1:0] subset_number;
        logic [SLOT_W-1:0]   slot_in_subset;
    } t_in_beat;

    typedef struct packed {
        logic [ANGLE_W-1:0]  angle_index;
        logic [STATUS_W-1:0] status;
    } t_out_beat;

    typedef struct packed {
        logic busy;
        logic done;
        logic fa_we;
    } t_bld_stat;

endpackage

>>> src/ordered_subset_angle_order.sv
// ordered_subset_angle_order: top level with APB registers, beat handshake,
// first-angle memory and lookup path. Depends on osao_pkg, osao_mul, osao_build.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one beat per item:
//   a build beat orders the subset first angles, a lookup beat returns
//   first_angle[subset] + S * slot. Every item gives one output beat on
//   o_out_valid / i_out_ready / o_out_data.
//   Lookup: one item at a time; the shared multiplier and the registered
//   memory read feed r_angle in T_LOOK, then T_FIN loads the output register
//   once it is free, and no new item is taken before T_FIN is left.
//   Build: one candidate per cycle through the shared multiplier and the
//   cost memory, S-1 rounds over S-1 candidates.
//   o_in_ready is high only when no item is in flight; a finished beat held
//   in the output register does not block the next accept, but a second
//   result waits until the receiver takes the first.
//   Reset: S = 1, A = 1, table not built, lookups report status 2.
//   Any register write clears the built mark. Write registers only when idle.
module ordered_subset_angle_order
    import osao_pkg::*;
#(
    parameter int MAX_SUBSETS = 64,
    parameter int MAX_ANGLES_PER_SUBSET = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_beat    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_beat   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int S_W  = $clog2(MAX_SUBSETS + 1);
    localparam int I_W  = $clog2(MAX_SUBSETS);
    localparam int A_W  = $clog2(MAX_ANGLES_PER_SUBSET + 1);
    localparam int MB_W = (S_W > SLOT_W) ? S_W : SLOT_W;
    localparam int P_W  = S_W + MB_W;
    localparam int L_W  = ((P_W > ANGLE_W) ? P_W : ANGLE_W) + 1;
    localparam int X_W  = (I_W > SUBSET_W) ? I_W : SUBSET_W;

    localparam logic [1:0] T_IDLE  = 2'd0;
    localparam logic [1:0] T_LOOK  = 2'd1;
    localparam logic [1:0] T_BUILD = 2'd2;
    localparam logic [1:0] T_FIN   = 2'd3;

    logic [1:0]          r_state;
    logic                r_built;
    logic [NSUB_W-1:0]   r_num_subsets;
    logic [NANG_W-1:0]   r_angles;
    logic                r_out_valid;
    t_out_beat           r_out_data;
    logic [STATUS_W-1:0] r_status;
    logic [ANGLE_W-1:0]  r_angle;

    logic [I_W-1:0]      r_fa_mem [MAX_SUBSETS];
    logic [I_W-1:0]      r_fa_rd;

    logic                cfg_wr;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic                accept;
    logic                out_free;
    logic [S_W-1:0]      s_eff;
    logic [A_W-1:0]      a_eff;
    logic [X_W-1:0]      sub_x;
    logic [I_W-1:0]      look_addr;
    logic                out_of_range;
    logic [S_W-1:0]      mul_a;
    logic [MB_W-1:0]     mul_b;
    logic [P_W-1:0]      prod;
    logic [L_W-1:0]      look_sum;

    t_bld_stat           bld_stat;
    logic [S_W-1:0]      bld_mul_a;
    logic [S_W-1:0]      bld_mul_b;
    logic [I_W-1:0]      fa_addr;
    logic [I_W-1:0]      fa_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[2 +: CFG_IDX_W];

    always_comb begin
        case (cfg_idx)
            REG_NUM_SUBSETS: prdata = 32'(r_num_subsets);
            REG_ANGLES:      prdata = 32'(r_angles);
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        if (r_num_subsets == '0) begin
            s_eff = S_W'(1);
        end else if (r_num_subsets > MAX_SUBSETS) begin
            s_eff = S_W'(MAX_SUBSETS);
        end else begin
            s_eff = S_W'(r_num_subsets);
        end
        if (r_angles == '0) begin
            a_eff = A_W'(1);
        end else if (r_angles > MAX_ANGLES_PER_SUBSET) begin
            a_eff = A_W'(MAX_ANGLES_PER_SUBSET);
        end else begin
            a_eff = A_W'(r_angles);
        end
    end

    assign sub_x        = X_W'(i_in_data.subset_number);
    assign look_addr    = sub_x[I_W-1:0];
    assign out_of_range = (i_in_data.subset_number >= s_eff) ||
                          (i_in_data.slot_in_subset >= a_eff);

    assign o_in_ready = (r_state == T_IDLE);
    assign accept     = i_in_valid & o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign mul_a = bld_stat.busy ? bld_mul_a : s_eff;
    assign mul_b = bld_stat.busy ? MB_W'(bld_mul_b) : MB_W'(i_in_data.slot_in_subset);

    osao_mul #(
        .A_W (S_W),
        .B_W (MB_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    osao_build #(
        .MAX_SUBSETS (MAX_SUBSETS)
    ) u_build (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept && (i_in_data.operation == OP_BUILD)),
        .i_s       (s_eff),
        .i_prod    (prod[2*S_W-1:0]),
        .o_mul_a   (bld_mul_a),
        .o_mul_b   (bld_mul_b),
        .o_stat    (bld_stat),
        .o_fa_addr (fa_addr),
        .o_fa_data (fa_data)
    );

    always_ff @(posedge i_clk) begin
        r_fa_rd <= r_fa_mem[look_addr];
        if (bld_stat.fa_we) begin
            r_fa_mem[fa_addr] <= fa_data;
        end
    end

    assign look_sum = L_W'(r_fa_rd) + L_W'(prod);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (i_in_data.operation == OP_BUILD) begin
                r_status <= ST_OK;
            end else if (!r_built) begin
                r_status <= ST_NOBUILD;
            end else if (out_of_range) begin
                r_status <= ST_RANGE;
            end else begin
                r_status <= ST_OK;
            end
            r_angle <= '0;
        end
        if (r_state == T_LOOK && r_status == ST_OK) begin
            r_angle <= look_sum[ANGLE_W-1:0];
        end
        if (r_state == T_FIN && out_free) begin
            r_out_data.angle_index <= r_angle;
            r_out_data.status      <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= T_IDLE;
            r_built       <= 1'b0;
            r_num_subsets <= NSUB_W'(1);
            r_angles      <= NANG_W'(1);
            r_out_valid   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_NUM_SUBSETS: r_num_subsets <= pwdata[NSUB_W-1:0];
                    REG_ANGLES:      r_angles      <= pwdata[NANG_W-1:0];
                    default: ;
                endcase
                r_built <= 1'b0;
            end
            if (bld_stat.done) begin
                r_built <= 1'b1;
            end
            if (r_state == T_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        r_state <= (i_in_data.operation == OP_BUILD) ? T_BUILD : T_LOOK;
                    end
                end
                T_LOOK: begin
                    r_state <= T_FIN;
                end
                T_BUILD: begin
                    if (bld_stat.done) begin
                        r_state <= T_FIN;
                    end
                end
                T_FIN: begin
                    if (out_free) begin
                        r_state <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_ready_not_building: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !bld_stat.busy)
        else $error("input ready while build sequencer busy");

    a_done_sets_built: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bld_stat.done |=> r_built)
        else $error("build finished without marking table built");

    a_cfg_clears_built: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> !r_built)
        else $error("register write did not clear built mark");

    a_error_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |-> (o_out_data.angle_index == '0))
        else $error("error beat carries nonzero angle");

endmodule

>>> src/osao_mul.sv
// osao_mul: shared unsigned multiplier with a registered product.
// Used by the build sequencer and by lookups. Depends on nothing.
module osao_mul #(
    parameter int A_W = 7,
    parameter int B_W = 8
) (
    input  logic               i_clk,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_p
);

    logic [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
    end

    assign o_p = r_p;

endmodule

>>> src/osao_build.sv
// osao_build: greedy first-angle sequencer, one candidate per cycle per round.
// Holds the running cost memory and placed marks. Depends on osao_pkg and
// uses the shared multiplier of the top level, whose product is registered.
module osao_build
    import osao_pkg::*;
#(
    parameter int MAX_SUBSETS = 64,
    parameter int S_W = $clog2(MAX_SUBSETS + 1),
    parameter int I_W = $clog2(MAX_SUBSETS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [S_W-1:0]   i_s,
    input  logic [2*S_W-1:0] i_prod,
    output logic [S_W-1:0]   o_mul_a,
    output logic [S_W-1:0]   o_mul_b,
    output t_bld_stat        o_stat,
    output logic [I_W-1:0]   o_fa_addr,
    output logic [I_W-1:0]   o_fa_data
);

    localparam int C_W   = 2 * S_W;
    localparam int SUM_W = C_W + I_W;

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_SQ    = 3'd1;
    localparam logic [2:0] B_SQW   = 3'd2;
    localparam logic [2:0] B_SCAN  = 3'd3;
    localparam logic [2:0] B_DRAIN = 3'd4;
    localparam logic [2:0] B_PICK  = 3'd5;
    localparam logic [2:0] B_DONE  = 3'd6;

    logic [2:0]             r_state;
    logic [MAX_SUBSETS-1:0] r_placed;
    logic [I_W-1:0]         r_last_pick;
    logic [I_W-1:0]         r_round;
    logic [I_W-1:0]         r_i;
    logic [C_W-1:0]         r_s_sq;
    logic                   r_v1;
    logic [I_W-1:0]         r_idx1;
    logic                   r_found;
    logic [I_W-1:0]         r_best;
    logic [SUM_W-1:0]       r_best_sum;
    logic [C_W-1:0]         r_best_cost;

    logic [SUM_W-1:0]       r_cost_mem [MAX_SUBSETS];
    logic [SUM_W-1:0]       r_cost_rd;

    logic [I_W-1:0]         d_abs;
    logic [S_W-1:0]         s_m1;
    logic [C_W-1:0]         n_cost;
    logic [SUM_W-1:0]       n_sum;
    logic                   better;

    assign s_m1  = i_s - S_W'(1);
    assign d_abs = (r_i >= r_last_pick) ? (r_i - r_last_pick) : (r_last_pick - r_i);

    always_comb begin
        o_mul_a = i_s;
        o_mul_b = i_s;
        if (r_state == B_SCAN) begin
            o_mul_a = S_W'(d_abs);
            o_mul_b = i_s - S_W'(d_abs);
        end
    end

    // cost = s^2 - 2*d*(s-d); first round starts the sums from zero
    assign n_cost = r_s_sq - {i_prod[C_W-2:0], 1'b0};
    assign n_sum  = ((r_round == I_W'(1)) ? '0 : r_cost_rd) + SUM_W'(n_cost);
    assign better = !r_found || (n_sum < r_best_sum) ||
                    ((n_sum == r_best_sum) && (n_cost < r_best_cost));

    assign o_stat.busy  = (r_state != B_IDLE);
    assign o_stat.done  = (r_state == B_DONE);
    assign o_stat.fa_we = ((r_state == B_IDLE) && i_start) || (r_state == B_PICK);
    assign o_fa_addr    = (r_state == B_PICK) ? r_round : '0;
    assign o_fa_data    = (r_state == B_PICK) ? r_best : '0;

    always_ff @(posedge i_clk) begin
        r_cost_rd <= r_cost_mem[r_i];
        if (r_v1) begin
            r_cost_mem[r_idx1] <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_placed    <= '0;
            r_last_pick <= '0;
            r_round     <= '0;
            r_i         <= '0;
            r_v1        <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_v1 <= (r_state == B_SCAN) && !r_placed[r_i];
            if (r_v1 && better) begin
                r_found     <= 1'b1;
                r_best      <= r_idx1;
                r_best_sum  <= n_sum;
                r_best_cost <= n_cost;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_start) begin
                        r_placed    <= MAX_SUBSETS'(1);
                        r_last_pick <= '0;
                        r_round     <= I_W'(1);
                        r_state     <= B_SQ;
                    end
                end
                B_SQ: begin
                    r_state <= B_SQW;
                end
                B_SQW: begin
                    r_s_sq <= i_prod;
                    r_i    <= I_W'(1);
                    r_found <= 1'b0;
                    r_state <= (i_s == S_W'(1)) ? B_DONE : B_SCAN;
                end
                B_SCAN: begin
                    r_idx1 <= r_i;
                    if (S_W'(r_i) == s_m1) begin
                        r_state <= B_DRAIN;
                    end else begin
                        r_i <= r_i + I_W'(1);
                    end
                end
                B_DRAIN: begin
                    r_state <= B_PICK;
                end
                B_PICK: begin
                    r_placed[r_best] <= 1'b1;
                    r_last_pick      <= r_best;
                    if (S_W'(r_round) == s_m1) begin
                        r_state <= B_DONE;
                    end else begin
                        r_round <= r_round + I_W'(1);
                        r_i     <= I_W'(1);
                        r_found <= 1'b0;
                        r_state <= B_SCAN;
                    end
                end
                B_DONE: begin
                    r_state <= B_IDLE;
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

>>> bench/osao_checker.sv
// osao_checker: watches the input, output and register ports of the subset angle
// ordering block, predicts each result beat and compares it field by field.
// Depends on osao_pkg.
`timescale 1ns / 100ps
module osao_checker
    import osao_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_beat    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_beat   i_out_data,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_pending,
    output int          o_mismatch_count
);

    localparam int SUBSETS_MAX = 64;
    localparam int ANGLES_MAX  = 256;

    logic [NSUB_W-1:0]   nsub_reg;
    logic [NANG_W-1:0]   nang_reg;
    logic [SUBSET_W-1:0] first_angle [SUBSETS_MAX];
    logic                placed      [SUBSETS_MAX];
    logic [18:0]         cost_sum    [SUBSETS_MAX];
    logic [SUBSET_W-1:0] last_pick;
    logic                table_built;
    t_out_beat           angle_results_q[$];

    function automatic int subsets_eff();
        int s;
        s = int'(nsub_reg);
        if (s < 1) s = 1;
        if (s > SUBSETS_MAX) s = SUBSETS_MAX;
        return s;
    endfunction

    function automatic int angles_eff();
        int a;
        a = int'(nang_reg);
        if (a < 1) a = 1;
        if (a > ANGLES_MAX) a = ANGLES_MAX;
        return a;
    endfunction

    function automatic void clear_order();
        for (int i = 0; i < SUBSETS_MAX; i++) begin
            first_angle[i] = '0;
            placed[i]      = 1'b0;
            cost_sum[i]    = '0;
        end
        last_pick = '0;
    endfunction

    // greedy spread ordering of the first angle of every subset
    function automatic void order_first_angles();
        int s, d, c, cs, best, best_sum, best_cost, prev;
        logic found;
        s = subsets_eff();
        clear_order();
        placed[0] = 1'b1;
        for (int round = 1; round < s; round++) begin
            found = 1'b0;
            best = 0;
            best_sum = 0;
            best_cost = 0;
            prev = int'(last_pick);
            for (int i = 1; i < s; i++) begin
                if (!placed[i]) begin
                    d = (i >= prev) ? i - prev : prev - i;
                    c = d * d + (s - d) * (s - d);
                    cost_sum[i] = cost_sum[i] + c[18:0];
                    cs = int'(cost_sum[i]);
                    if (!found || cs < best_sum || (cs == best_sum && c < best_cost)) begin
                        found = 1'b1;
                        best = i;
                        best_sum = cs;
                        best_cost = c;
                    end
                end
            end
            if (found) begin
                first_angle[round] = best[SUBSET_W-1:0];
                placed[best]       = 1'b1;
                cost_sum[best]     = '0;
                last_pick          = best[SUBSET_W-1:0];
            end
        end
        table_built = 1'b1;
    endfunction

    function automatic t_out_beat predict_angle(t_in_beat b);
        t_out_beat r;
        int sum;
        r.angle_index = '0;
        r.status      = ST_OK;
        if (b.operation == OP_BUILD) begin
            order_first_angles();
        end else if (!table_built) begin
            r.status = ST_NOBUILD;
        end else if (int'(b.subset_number) >= subsets_eff() ||
                     int'(b.slot_in_subset) >= angles_eff()) begin
            r.status = ST_RANGE;
        end else begin
            sum = int'(first_angle[b.subset_number]) + subsets_eff() * int'(b.slot_in_subset);
            r.angle_index = sum[ANGLE_W-1:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat exp_beat;
        if (!i_rst_n) begin
            nsub_reg = NSUB_W'(1);
            nang_reg = NANG_W'(1);
            clear_order();
            table_built = 1'b0;
            angle_results_q.delete();
            o_mismatch_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_NUM_SUBSETS) begin
                    nsub_reg = i_pwdata[NSUB_W-1:0];
                end else begin
                    nang_reg = i_pwdata[NANG_W-1:0];
                end
                table_built = 1'b0;
            end
            if (i_in_valid && i_in_ready) begin
                angle_results_q.push_back(predict_angle(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (angle_results_q.size() == 0) begin
                    o_mismatch_count++;
                    $display("%0t: unexpected result beat angle_index %0d status %0d",
                             $time, i_out_data.angle_index, i_out_data.status);
                end else begin
                    exp_beat = angle_results_q.pop_front();
                    if (i_out_data.angle_index !== exp_beat.angle_index) begin
                        o_mismatch_count++;
                        $display("%0t: angle_index mismatch expected %0d actual %0d",
                                 $time, exp_beat.angle_index, i_out_data.angle_index);
                    end
                    if (i_out_data.status !== exp_beat.status) begin
                        o_mismatch_count++;
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, exp_beat.status, i_out_data.status);
                    end
                end
            end
        end
        o_pending = angle_results_q.size();
    end

endmodule

>>> bench/ordered_subset_angle_order_tb.sv
// ordered_subset_angle_order_tb: stimulus and verdict for the subset angle ordering
// block; directed corners, then random register phases with bursty traffic.
// Depends on osao_pkg, ordered_subset_angle_order and osao_checker.
`timescale 1ns / 100ps
module ordered_subset_angle_order_tb;
    import osao_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_TARGET = 1950;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_beat    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_beat   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int pending_results;
    int mismatch_total;
    int cycle_count;
    int items_sent;
    int hold_left;
    int s_eff;
    int a_eff;
    int rx_mode;
    int rx_mode_left;
    int rx_tick;

    ordered_subset_angle_order u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    osao_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_in_data        (i_in_data),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_out_data       (o_out_data),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_pending        (pending_results),
        .o_mismatch_count (mismatch_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: own stall pattern, plus a long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_mode_left = $urandom_range(50, 400);
                end
                rx_mode_left--;
                rx_tick++;
                case (rx_mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 1) != 0);
                    2: i_out_ready <= ($urandom_range(0, 3) != 0);
                    default: i_out_ready <= ((rx_tick % 7) < 4);
                endcase
            end
        end
    end

    function automatic t_in_beat make_beat(logic op, int sub, int slot);
        t_in_beat b;
        b.operation      = op;
        b.subset_number  = sub[SUBSET_W-1:0];
        b.slot_in_subset = slot[SLOT_W-1:0];
        return b;
    endfunction

    task automatic send_beat(t_in_beat b);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic idle_cycles(int n);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        int v;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_NUM_SUBSETS) begin
            v = value & 32'h7f;
            s_eff = (v < 1) ? 1 : (v > 64) ? 64 : v;
        end else begin
            v = value & 32'h1ff;
            a_eff = (v < 1) ? 1 : (v > 256) ? 256 : v;
        end
    endtask

    function automatic int pick_subsets();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 0;
                    1: return 1;
                    2: return 64;
                    default: return 127;
                endcase
            end
            8: return $urandom_range(17, 64);
            9: return $urandom_range(65, 127);
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    function automatic int pick_angles();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 256;
            2: return $urandom_range(257, 511);
            3: return $urandom_range(1, 4);
            default: return $urandom_range(1, 256);
        endcase
    endfunction

    function automatic int junk_upper(int v);
        if ($urandom_range(0, 3) == 0) return v | ($urandom() & 32'hffff_fe00);
        return v;
    endfunction

    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            send_beat(make_beat(OP_BUILD, $urandom_range(0, 63), $urandom_range(0, 255)));
        end else if (pick < 83) begin
            send_beat(make_beat(OP_LOOKUP, $urandom_range(0, s_eff - 1),
                                $urandom_range(0, a_eff - 1)));
        end else begin
            send_beat(make_beat(OP_LOOKUP, $urandom_range(0, 63), $urandom_range(0, 255)));
        end
    endtask

    initial begin
        int phase;
        int n_items;
        int burst_left;
        int gap;
        logic no_gaps;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_eff      = 1;
        a_eff      = 1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: lookup before build, then single subset corners
        send_beat(make_beat(OP_LOOKUP, 0, 0));
        send_beat(make_beat(OP_BUILD, 0, 0));
        send_beat(make_beat(OP_LOOKUP, 0, 0));
        send_beat(make_beat(OP_LOOKUP, 0, 1));
        send_beat(make_beat(OP_LOOKUP, 1, 0));

        wait_drained();
        write_reg(REG_NUM_SUBSETS, 64);
        write_reg(REG_ANGLES, 256);
        send_beat(make_beat(OP_LOOKUP, 63, 255));
        send_beat(make_beat(OP_BUILD, 0, 0));
        send_beat(make_beat(OP_LOOKUP, 63, 255));
        send_beat(make_beat(OP_LOOKUP, 0, 0));
        send_beat(make_beat(OP_LOOKUP, 42, 170));
        send_beat(make_beat(OP_LOOKUP, 21, 85));

        // zero registers saturate up to one
        wait_drained();
        write_reg(REG_NUM_SUBSETS, 0);
        write_reg(REG_ANGLES, 0);
        send_beat(make_beat(OP_BUILD, 63, 255));
        send_beat(make_beat(OP_LOOKUP, 0, 0));
        send_beat(make_beat(OP_LOOKUP, 0, 1));
        send_beat(make_beat(OP_LOOKUP, 63, 255));

        // oversized registers saturate down
        wait_drained();
        write_reg(REG_NUM_SUBSETS, 127);
        write_reg(REG_ANGLES, 511);
        send_beat(make_beat(OP_BUILD, 0, 0));
        send_beat(make_beat(OP_LOOKUP, 63, 255));
        send_beat(make_beat(OP_LOOKUP, 17, 200));

        wait_drained();
        write_reg(REG_NUM_SUBSETS, 5);
        write_reg(REG_ANGLES, 3);
        send_beat(make_beat(OP_BUILD, 0, 0));
        send_beat(make_beat(OP_LOOKUP, 4, 2));
        send_beat(make_beat(OP_LOOKUP, 4, 3));
        send_beat(make_beat(OP_LOOKUP, 5, 0));

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_drained();
            case ($urandom_range(0, 3))
                0: write_reg(REG_NUM_SUBSETS, junk_upper(pick_subsets()));
                1: write_reg(REG_ANGLES, junk_upper(pick_angles()));
                default: begin
                    write_reg(REG_NUM_SUBSETS, junk_upper(pick_subsets()));
                    write_reg(REG_ANGLES, junk_upper(pick_angles()));
                end
            endcase
            if ($urandom_range(0, 2) == 0) begin
                send_beat(make_beat(OP_LOOKUP, $urandom_range(0, 63), $urandom_range(0, 255)));
            end
            send_beat(make_beat(OP_BUILD, $urandom_range(0, 63), $urandom_range(0, 255)));
            if (phase == 1) begin
                hold_left = 400;
            end
            no_gaps = (phase % 3 == 0);
            n_items = $urandom_range(80, 200);
            burst_left = $urandom_range(1, 24);
            for (int k = 0; k < n_items && items_sent < ITEM_TARGET; k++) begin
                if (phase == 3 && k == n_items / 2) begin
                    wait_drained();
                end
                random_item();
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    if (!no_gaps && gap > 0) begin
                        idle_cycles(gap);
                    end
                end
            end
            phase++;
        end

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (mismatch_total == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/osao_pkg.sv
src/osao_mul.sv
src/osao_build.sv
src/ordered_subset_angle_order.sv
bench/osao_checker.sv
bench/ordered_subset_angle_order_tb.sv
